/* design/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    // Default sizing
    localparam int DEPTH_DEF  = 16;
    localparam int PRIO_W_DEF = 8;
    localparam int DATA_W     = 32;

    // Request opcodes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture request and compare against all slots
        logic exec;   // apply shift, update count and result registers
    } t_ctrl_cmd;

endpackage

`default_nettype wire

/* design/spq_ctrl.sv */
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_ctrl_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_acc;

    // Take a request only in idle, when the result register is free or draining now
    assign in_acc = i_valid && o_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_ready  = 1'b0;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = !r_out_valid || i_ready;
                o_cmd.load = i_valid && (!r_out_valid || i_ready);
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* design/spq_datapath.sv */
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int PRIO_W = PRIO_W_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ctrl_cmd                i_cmd,
    input  wire logic                     i_action,
    input  wire logic signed [DATA_W-1:0] i_item_data,
    input  wire logic [PRIO_W-1:0]        i_item_priority,
    output logic [1:0]                    o_status,
    output logic                          o_removed_valid,
    output logic signed [DATA_W-1:0]      o_removed_data,
    output logic [PRIO_W-1:0]             o_removed_priority,
    output logic signed [DATA_W-1:0]      o_head_data,
    output logic signed [DATA_W-1:0]      o_tail_data,
    output logic [CNT_W-1:0]              o_entry_count,
    output logic                          o_is_empty
);

    // Slot row: slot 0 is the head
    logic [DATA_W-1:0] r_slot_data [DEPTH];
    logic [PRIO_W-1:0] r_slot_prio [DEPTH];
    logic [DATA_W-1:0] n_slot_data [DEPTH];
    logic [PRIO_W-1:0] n_slot_prio [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [DATA_W-1:0] r_tail;
    logic [DATA_W-1:0] n_tail;

    // Captured request
    logic              r_act;
    logic [DATA_W-1:0] r_data;
    logic [PRIO_W-1:0] r_prio;
    logic [DEPTH-1:0]  r_keep;     // slot stays in place on insert
    logic [DEPTH-1:0]  occ;
    logic [DEPTH-1:0]  keep_now;

    // Result registers
    t_status           r_status;
    logic              r_rem_valid;
    logic [DATA_W-1:0] r_rem_data;
    logic [PRIO_W-1:0] r_rem_prio;
    logic [DATA_W-1:0] r_head;
    logic [DATA_W-1:0] r_tail_out;
    logic [CNT_W-1:0]  r_cnt_out;

    t_status           n_status;
    logic              do_ins;
    logic              do_rem;
    logic              at_end;

    // Per-cell occupancy and priority compare (prefix, list is sorted)
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cmp
            assign occ[g]      = CNT_W'(g) < r_count;
            assign keep_now[g] = occ[g] && !(r_slot_prio[g] < i_item_priority);
        end
    endgenerate

    // Status decision
    always_comb begin
        n_status = STAT_OK;
        if (r_act == ACT_INSERT) begin
            if (r_count == CNT_W'(DEPTH)) begin
                n_status = STAT_FULL;
            end
        end else begin
            if (r_count == '0) begin
                n_status = STAT_EMPTY;
            end
        end
    end

    assign do_ins = (r_act == ACT_INSERT) && (n_status == STAT_OK);
    assign do_rem = (r_act == ACT_REMOVE) && (n_status == STAT_OK);
    // New item lands after every occupied slot
    assign at_end = &(r_keep | ~occ);

    // Per-cell next value: keep, take the new item, or shift
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_W-1:0] up_data;
            logic [PRIO_W-1:0] up_prio;
            logic [DATA_W-1:0] dn_data;
            logic [PRIO_W-1:0] dn_prio;
            logic              prev_keep;
            if (g == 0) begin : g_first
                assign up_data   = r_slot_data[g];
                assign up_prio   = r_slot_prio[g];
                assign prev_keep = 1'b1;
            end else begin : g_rest
                assign up_data   = r_slot_data[g-1];
                assign up_prio   = r_slot_prio[g-1];
                assign prev_keep = r_keep[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign dn_data = r_slot_data[g];
                assign dn_prio = r_slot_prio[g];
            end else begin : g_mid
                assign dn_data = r_slot_data[g+1];
                assign dn_prio = r_slot_prio[g+1];
            end
            always_comb begin
                n_slot_data[g] = r_slot_data[g];
                n_slot_prio[g] = r_slot_prio[g];
                if (do_ins && !r_keep[g]) begin
                    if (prev_keep) begin
                        n_slot_data[g] = r_data;
                        n_slot_prio[g] = r_prio;
                    end else begin
                        n_slot_data[g] = up_data;
                        n_slot_prio[g] = up_prio;
                    end
                end else if (do_rem) begin
                    n_slot_data[g] = dn_data;
                    n_slot_prio[g] = dn_prio;
                end
            end
        end
    endgenerate

    // Count and tail tracking
    always_comb begin
        n_count = r_count;
        n_tail  = r_tail;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
            if (at_end) begin
                n_tail = r_data;
            end
        end else if (do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_data <= i_item_data;
            r_prio <= i_item_priority;
            r_keep <= keep_now;
        end
    end

    // Slot row and tail payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_slot_data[i] <= n_slot_data[i];
                r_slot_prio[i] <= n_slot_prio[i];
            end
            r_tail <= n_tail;
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_rem_valid <= do_rem;
            r_rem_data  <= do_rem ? r_slot_data[0] : '0;
            r_rem_prio  <= do_rem ? r_slot_prio[0] : '0;
            r_head      <= (n_count != '0) ? n_slot_data[0] : '0;
            r_tail_out  <= (n_count != '0) ? n_tail : '0;
            r_cnt_out   <= n_count;
        end
    end

    assign o_status           = r_status;
    assign o_removed_valid    = r_rem_valid;
    assign o_removed_data     = r_rem_data;
    assign o_removed_priority = r_rem_prio;
    assign o_head_data        = r_head;
    assign o_tail_data        = r_tail_out;
    assign o_entry_count      = r_cnt_out;
    assign o_is_empty         = (r_cnt_out == '0);

endmodule

`default_nettype wire

/* design/sorted_priority_queue_unit.sv */
// Each slot compares its priority in parallel when a request is accepted;
// the whole slot row shifts and the results are captured in the EXEC state.
// No new request is taken until EXEC is done. Results wait in an output
// register; a new request is taken when that register is free or draining.
// Reset (synchronous, active low) empties the queue; slot contents are kept.
`default_nettype none

module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int PRIO_W = PRIO_W_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_action,
    input  wire logic signed [DATA_W-1:0] i_item_data,
    input  wire logic [PRIO_W-1:0]        i_item_priority,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [1:0]                    o_status,
    output logic                          o_removed_valid,
    output logic signed [DATA_W-1:0]      o_removed_data,
    output logic [PRIO_W-1:0]             o_removed_priority,
    output logic signed [DATA_W-1:0]      o_head_data,
    output logic signed [DATA_W-1:0]      o_tail_data,
    output logic [CNT_W-1:0]              o_entry_count,
    output logic                          o_is_empty
);

    t_ctrl_cmd cmd;

    // Sequencer
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // Slot row and result registers
    spq_datapath #(
        .DEPTH  (DEPTH),
        .PRIO_W (PRIO_W)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_action           (i_action),
        .i_item_data        (i_item_data),
        .i_item_priority    (i_item_priority),
        .o_status           (o_status),
        .o_removed_valid    (o_removed_valid),
        .o_removed_data     (o_removed_data),
        .o_removed_priority (o_removed_priority),
        .o_head_data        (o_head_data),
        .o_tail_data        (o_tail_data),
        .o_entry_count      (o_entry_count),
        .o_is_empty         (o_is_empty)
    );

endmodule

`default_nettype wire

/* tb/spq_result_checker.sv */
`timescale 1ns / 1ps

module spq_result_checker
    import spq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int PRIO_W = PRIO_W_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request channel
    input  wire logic                     i_req_valid,
    input  wire logic                     i_req_ready,
    input  wire logic                     i_req_action,
    input  wire logic signed [DATA_W-1:0] i_req_data,
    input  wire logic [PRIO_W-1:0]        i_req_priority,
    // result channel
    input  wire logic                     i_res_valid,
    input  wire logic                     i_res_ready,
    input  wire logic [1:0]               i_status,
    input  wire logic                     i_removed_valid,
    input  wire logic signed [DATA_W-1:0] i_removed_data,
    input  wire logic [PRIO_W-1:0]        i_removed_priority,
    input  wire logic signed [DATA_W-1:0] i_head_data,
    input  wire logic signed [DATA_W-1:0] i_tail_data,
    input  wire logic [CNT_W-1:0]         i_entry_count,
    input  wire logic                     i_is_empty,
    // tallies for the top
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_full_hits,
    output int                            o_empty_hits
);

    typedef struct packed {
        t_status                  status;
        logic                     removed_valid;
        logic signed [DATA_W-1:0] removed_data;
        logic [PRIO_W-1:0]        removed_priority;
        logic signed [DATA_W-1:0] head_data;
        logic signed [DATA_W-1:0] tail_data;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
    } t_queue_outcome;

    // Shadow copy of the sorted slot row, head at index 0
    logic signed [DATA_W-1:0] shadow_data [DEPTH];
    logic [PRIO_W-1:0]        shadow_prio [DEPTH];
    int                       shadow_count = 0;

    t_queue_outcome outcomes_due [$];
    t_queue_outcome due;
    int fail_tally    = 0;
    int checked_tally = 0;
    int full_tally    = 0;
    int empty_tally   = 0;

    // Apply one request to the shadow queue and return what the block must report
    function automatic t_queue_outcome advance_queue_model(
        input logic                     act,
        input logic signed [DATA_W-1:0] data,
        input logic [PRIO_W-1:0]        prio
    );
        t_queue_outcome res;
        int             slot;
        bit             found;
        res = '0;
        res.status = STAT_OK;
        if (act == ACT_INSERT) begin
            if (shadow_count >= DEPTH) begin
                res.status = STAT_FULL;
            end else begin
                // lands ahead of the first strictly lower priority, so ties keep arrival order
                slot = shadow_count;
                found = 1'b0;
                for (int i = 0; i < shadow_count; i++) begin
                    if (!found && shadow_prio[i] < prio) begin
                        slot = i;
                        found = 1'b1;
                    end
                end
                for (int i = shadow_count; i > slot; i--) begin
                    shadow_data[i] = shadow_data[i-1];
                    shadow_prio[i] = shadow_prio[i-1];
                end
                shadow_data[slot] = data;
                shadow_prio[slot] = prio;
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            res.status = STAT_EMPTY;
        end else begin
            res.removed_valid    = 1'b1;
            res.removed_data     = shadow_data[0];
            res.removed_priority = shadow_prio[0];
            for (int i = 0; i + 1 < shadow_count; i++) begin
                shadow_data[i] = shadow_data[i+1];
                shadow_prio[i] = shadow_prio[i+1];
            end
            shadow_count--;
        end
        // head and tail read as zero when empty
        if (shadow_count > 0) begin
            res.head_data = shadow_data[0];
            res.tail_data = shadow_data[shadow_count-1];
        end
        res.entry_count = CNT_W'(shadow_count);
        res.is_empty    = (shadow_count == 0);
        return res;
    endfunction

    function automatic void check_field(
        input string             field,
        input logic [DATA_W-1:0] want,
        input logic [DATA_W-1:0] got
    );
        if (got !== want) begin
            fail_tally++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endfunction

    // Watch both channels; a result never belongs to a request taken on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            outcomes_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (outcomes_due.size() == 0) begin
                    fail_tally++;
                    $display("%0t: unexpected result, expected none, got status %0d count %0d",
                             $time, i_status, i_entry_count);
                end else begin
                    due = outcomes_due.pop_front();
                    check_field("status", DATA_W'(due.status), DATA_W'(i_status));
                    check_field("removed_valid", DATA_W'(due.removed_valid),
                                DATA_W'(i_removed_valid));
                    check_field("removed_data", due.removed_data, i_removed_data);
                    check_field("removed_priority", DATA_W'(due.removed_priority),
                                DATA_W'(i_removed_priority));
                    check_field("head_data", due.head_data, i_head_data);
                    check_field("tail_data", due.tail_data, i_tail_data);
                    check_field("entry_count", DATA_W'(due.entry_count),
                                DATA_W'(i_entry_count));
                    check_field("is_empty", DATA_W'(due.is_empty), DATA_W'(i_is_empty));
                    checked_tally++;
                end
            end
            if (i_req_valid && i_req_ready) begin
                due = advance_queue_model(i_req_action, i_req_data, i_req_priority);
                if (due.status == STAT_FULL) full_tally++;
                if (due.status == STAT_EMPTY) empty_tally++;
                outcomes_due.push_back(due);
            end
        end
        o_fail_count <= fail_tally;
        o_pending    <= outcomes_due.size();
        o_checked    <= checked_tally;
        o_full_hits  <= full_tally;
        o_empty_hits <= empty_tally;
    end

endmodule

/* tb/tb_sorted_priority_queue_unit.sv */
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;
    import spq_pkg::*;

    localparam int CNT_W        = $clog2(DEPTH_DEF + 1);
    localparam int N_RANDOM     = 1230;
    localparam int DRAIN_CYCLES = 20;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_valid         = 1'b0;
    logic                     i_action        = ACT_INSERT;
    logic signed [DATA_W-1:0] i_item_data     = '0;
    logic [PRIO_W_DEF-1:0]    i_item_priority = '0;
    logic                     i_ready         = 1'b0;

    logic                     o_ready;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic                     o_removed_valid;
    logic signed [DATA_W-1:0] o_removed_data;
    logic [PRIO_W_DEF-1:0]    o_removed_priority;
    logic signed [DATA_W-1:0] o_head_data;
    logic signed [DATA_W-1:0] o_tail_data;
    logic [CNT_W-1:0]         o_entry_count;
    logic                     o_is_empty;

    int fail_count, pending_count, checked_count, full_count, empty_count;
    int insert_count = 0;
    int remove_count = 0;
    bit quiet = 1'b0;   // no idling on either side while set

    always #4 i_clk = ~i_clk;

    sorted_priority_queue_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_item_data        (i_item_data),
        .i_item_priority    (i_item_priority),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_removed_valid    (o_removed_valid),
        .o_removed_data     (o_removed_data),
        .o_removed_priority (o_removed_priority),
        .o_head_data        (o_head_data),
        .o_tail_data        (o_tail_data),
        .o_entry_count      (o_entry_count),
        .o_is_empty         (o_is_empty)
    );

    spq_result_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_ready        (o_ready),
        .i_req_action       (i_action),
        .i_req_data         (i_item_data),
        .i_req_priority     (i_item_priority),
        .i_res_valid        (o_valid),
        .i_res_ready        (i_ready),
        .i_status           (o_status),
        .i_removed_valid    (o_removed_valid),
        .i_removed_data     (o_removed_data),
        .i_removed_priority (o_removed_priority),
        .i_head_data        (o_head_data),
        .i_tail_data        (o_tail_data),
        .i_entry_count      (o_entry_count),
        .i_is_empty         (o_is_empty),
        .o_fail_count       (fail_count),
        .o_pending          (pending_count),
        .o_checked          (checked_count),
        .o_full_hits        (full_count),
        .o_empty_hits       (empty_count)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Data word biased toward the extremes
    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(
        input logic                     act,
        input logic signed [DATA_W-1:0] data,
        input logic [PRIO_W_DEF-1:0]    prio
    );
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= act;
        i_item_data     <= data;
        i_item_priority <= prio;
        do @(posedge i_clk); while (!o_ready);
        if (act == ACT_INSERT) insert_count++;
        else remove_count++;
    endtask

    // Result side back-pressure
    initial begin
        int run, g;
        wait (i_rst_n === 1'b1);
        forever begin
            i_ready <= 1'b1;
            run = $urandom_range(1, 16);
            repeat (run) @(posedge i_clk);
            g = idle_len();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int   sent, phase_len, style, remove_pct;
        logic act;
        logic [PRIO_W_DEF-1:0] prio;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // remove on an empty queue
        send_request(ACT_REMOVE, 32'sh7fffffff, 8'hff);
        // extreme data and priorities, ties at both ends and in the middle
        send_request(ACT_INSERT, 32'sh7fffffff, 8'd0);
        send_request(ACT_INSERT, 32'sh80000000, 8'd255);
        send_request(ACT_INSERT, -32'sd1, 8'd0);
        send_request(ACT_INSERT, 32'sd0, 8'd255);
        send_request(ACT_INSERT, 32'sh5555aaaa, 8'd128);
        send_request(ACT_INSERT, 32'shaaaa5555, 8'd128);
        // fill to capacity, then one insert that must be rejected
        repeat (10) send_request(ACT_INSERT, $urandom, 8'($urandom_range(0, 255)));
        send_request(ACT_INSERT, 32'sh12345678, 8'd200);
        repeat (2) send_request(ACT_REMOVE, $urandom, 8'($urandom));

        // random phases: balanced, filling, draining, and heavy priority ties
        sent = 0;
        while (sent < N_RANDOM) begin
            style     = $urandom_range(0, 3);
            quiet     = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 80);
            case (style)
                1:       remove_pct = 15;
                2:       remove_pct = 85;
                default: remove_pct = 50;
            endcase
            for (int k = 0; k < phase_len && sent < N_RANDOM; k++) begin
                act = ($urandom_range(0, 99) < remove_pct) ? ACT_REMOVE : ACT_INSERT;
                if (style == 3) prio = 8'($urandom_range(0, 3) * 85);
                else prio = 8'($urandom);
                send_request(act, rand_word(), prio);
                sent++;
            end
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        // let every outstanding result drain, then a few spare cycles
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d inserts and %0d removes; %0d results checked.",
                 insert_count, remove_count, checked_count);
        $display("Inserts into a full queue: %0d; removes from an empty queue: %0d.",
                 full_count, empty_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("Timeout with %0d results outstanding", pending_count);
        $display("Test completed with failures");
        $finish;
    end

endmodule
